>>> sv/bsdg_pkg.sv
package bsdg_pkg;

  // Fixed-point format of the point and of the results.
  localparam int FracBits  = 16;
  localparam int InW       = 24;
  localparam int DistW     = 25;
  localparam int GradW     = 18;

  // Offsets are at most 2^23 - 2^16 in magnitude, so 24 bits unsigned hold them.
  localparam int OffW      = 24;
  // Sum of three squared offsets.
  localparam int SumW      = 2 * OffW + 2;
  // Square root width and the number of root cells (one result bit per cell).
  localparam int RootW     = SumW / 2;
  // Numerator width of the gradient division: offset shifted by FracBits.
  localparam int NumW      = OffW + FracBits;
  // Quotient bits: the quotient never exceeds one, so FracBits + 1 bits.
  localparam int QuoW      = FracBits + 1;

  localparam logic signed [InW+1:0] One = (InW+2)'(1) <<< FracBits;

  // Item data handed down the chain of cells.
  typedef struct packed {
    logic                          eucl;    // Euclidean outside case
    logic        [2:0]             neg;     // offset sign per axis
    logic        [2:0][OffW-1:0]   off;     // offset magnitude per axis
    logic signed [DistW-1:0]       dval;    // distance for cases without root
    logic signed [2:0][GradW-1:0]  grad;    // gradient for cases without root
  } item_t;

  // Square-root work state.
  typedef struct packed {
    logic [SumW-1:0]  rem;
    logic [RootW-1:0] root;
  } sqrt_t;

  // Division work state for all three axes.
  typedef struct packed {
    logic [2:0][NumW-1:0] rem;
    logic [2:0][QuoW-1:0] quo;
  } div_t;

endpackage

>>> sv/bsdg_sqrt_cell.sv
// One restoring square-root step: decides one root bit and passes the item on.
module bsdg_sqrt_cell
  import bsdg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [5:0]  step,
  input  logic        vld_i,
  input  item_t       item_i,
  input  sqrt_t       sq_i,
  output logic        vld_o,
  output item_t       item_o,
  output sqrt_t       sq_o
);

  logic        vld_r;
  item_t       item_r;
  sqrt_t       sq_r, sq_nxt;
  logic [SumW+1:0] trial;
  logic [SumW+1:0] rem_ext;

  // Trial subtract (root << (step + 1)) | (1 << 2*step) from the remainder.
  always_comb begin
    rem_ext = (SumW+2)'(sq_i.rem);
    trial   = ({(SumW+2-RootW)'(0), sq_i.root} << (step + 6'd1))
              | ((SumW+2)'(1) << {step, 1'b0});
    sq_nxt  = sq_i;
    if (rem_ext >= trial) begin
      sq_nxt.rem  = SumW'(rem_ext - trial);
      sq_nxt.root = sq_i.root | (RootW'(1) << step);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
    item_r <= item_i;
    sq_r   <= sq_nxt;
  end

  assign vld_o  = vld_r;
  assign item_o = item_r;
  assign sq_o   = sq_r;

endmodule

>>> sv/bsdg_div_cell.sv
// One restoring division step on all three axes: one quotient bit per axis.
module bsdg_div_cell
  import bsdg_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [4:0]        step,
  input  logic              vld_i,
  input  item_t             item_i,
  input  logic [RootW-1:0]  root_i,
  input  div_t              dv_i,
  output logic              vld_o,
  output item_t             item_o,
  output logic [RootW-1:0]  root_o,
  output div_t              dv_o
);

  logic             vld_r;
  item_t            item_r;
  logic [RootW-1:0] root_r;
  div_t             dv_r, dv_nxt;
  logic [NumW+QuoW:0] shd;

  // Compare remainder against root << step; the quotient fits QuoW bits.
  always_comb begin
    dv_nxt = dv_i;
    shd    = (NumW+QuoW+1)'(root_i) << step;
    for (int a = 0; a < 3; a++) begin
      if ((NumW+QuoW+1)'(dv_i.rem[a]) >= shd) begin
        dv_nxt.rem[a] = NumW'((NumW+QuoW+1)'(dv_i.rem[a]) - shd);
        dv_nxt.quo[a] = dv_i.quo[a] | (QuoW'(1) << step);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
    item_r <= item_i;
    root_r <= root_i;
    dv_r   <= dv_nxt;
  end

  assign vld_o  = vld_r;
  assign item_o = item_r;
  assign root_o = root_r;
  assign dv_o   = dv_r;

endmodule

>>> sv/box_signed_distance_gradient.sv
// From start to out_valid: entry register, root cells, divider cells, output register.
// Throughput: one point per cycle; busy is held low, the chain of cells never stalls.
// The chain has one square-root cell per root bit and one divider cell per quotient bit.
// Reset (rst_n low, synchronous) empties the chain and sets Euclidean mode.
// The receiver cannot stall: out_valid marks each result for exactly one cycle.
module box_signed_distance_gradient
  import bsdg_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [InW-1:0]   in_coord_x,
  input  logic signed [InW-1:0]   in_coord_y,
  input  logic signed [InW-1:0]   in_coord_z,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic                    cfg_euclidean_mode,
  output logic                    out_valid,
  output logic signed [DistW-1:0] out_signed_distance,
  output logic signed [GradW-1:0] out_grad_x,
  output logic signed [GradW-1:0] out_grad_y,
  output logic signed [GradW-1:0] out_grad_z
);

  logic eucl_mode_r;
  logic in_acc;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign in_acc    = start && !busy;

  // Mode register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eucl_mode_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      eucl_mode_r <= cfg_euclidean_mode;
    end
  end

  // Front end: offsets, inside face search and max-norm pick.
  logic signed [InW+1:0] p   [3];
  logic signed [InW+1:0] o   [3];
  logic signed [InW+1:0] ab  [3];
  logic signed [InW+1:0] best;
  logic [1:0]            k;
  item_t                 it;
  logic [SumW-1:0]       sum;

  always_comb begin
    p[0] = (InW+2)'(in_coord_x);
    p[1] = (InW+2)'(in_coord_y);
    p[2] = (InW+2)'(in_coord_z);
    it   = '0;
    sum  = '0;
    k    = 2'd0;
    for (int a = 0; a < 3; a++) begin
      if (p[a] < -One) o[a] = p[a] + One;
      else if (p[a] > One) o[a] = p[a] - One;
      else o[a] = '0;
      it.neg[a] = o[a] < 0;
      it.off[a] = OffW'(o[a] < 0 ? -o[a] : o[a]);
      sum = sum + SumW'({(SumW-OffW)'(0), it.off[a]} * {(SumW-OffW)'(0), it.off[a]});
      ab[a] = p[a] < 0 ? -p[a] : p[a];
    end
    best = One <<< 1;
    if (eucl_mode_r) begin
      it.eucl = sum != '0;
      // Inside: nearest face, strict comparisons, x then y then z.
      for (int a = 0; a < 3; a++) begin
        if (p[a] + One < best) begin
          best = p[a] + One;
          it.grad = '0;
          it.grad[a] = -GradW'(One);
        end
        if (One - p[a] < best) begin
          best = One - p[a];
          it.grad = '0;
          it.grad[a] = GradW'(One);
        end
      end
      it.dval = DistW'(-best);
    end else begin
      if (ab[0] > ab[1]) k = (ab[0] > ab[2]) ? 2'd0 : 2'd2;
      else k = (ab[1] > ab[2]) ? 2'd1 : 2'd2;
      it.dval = DistW'(ab[k] - One);
      it.grad[k] = (p[k] > 0) ? GradW'(One) : -GradW'(One);
    end
  end

  logic  s0_vld_r;
  item_t s0_item_r;
  sqrt_t s0_sq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else begin
      s0_vld_r <= in_acc;
    end
    s0_item_r <= it;
    s0_sq_r   <= {sum, RootW'(0)};
  end

  // Square-root chain, most significant root bit first.
  logic  sv [RootW+1];
  item_t si [RootW+1];
  sqrt_t ss [RootW+1];

  assign sv[0] = s0_vld_r;
  assign si[0] = s0_item_r;
  assign ss[0] = s0_sq_r;

  for (genvar c = 0; c < RootW; c++) begin : g_sqrt
    bsdg_sqrt_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .step   (6'(RootW - 1 - c)),
      .vld_i  (sv[c]),
      .item_i (si[c]),
      .sq_i   (ss[c]),
      .vld_o  (sv[c+1]),
      .item_o (si[c+1]),
      .sq_o   (ss[c+1])
    );
  end

  // Division chain: |offset| << FracBits divided by the root.
  logic             dvv [QuoW+1];
  item_t            dvi [QuoW+1];
  logic [RootW-1:0] dvr [QuoW+1];
  div_t             dvd [QuoW+1];

  always_comb begin
    dvd[0] = '0;
    for (int a = 0; a < 3; a++) begin
      dvd[0].rem[a] = NumW'(si[RootW].off[a]) << FracBits;
    end
  end

  assign dvv[0] = sv[RootW];
  assign dvi[0] = si[RootW];
  // A zero root only occurs off the Euclidean outside path; avoid an all-ones quotient.
  assign dvr[0] = (ss[RootW].root == '0) ? RootW'(1) : ss[RootW].root;

  for (genvar c = 0; c < QuoW; c++) begin : g_div
    bsdg_div_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .step   (5'(QuoW - 1 - c)),
      .vld_i  (dvv[c]),
      .item_i (dvi[c]),
      .root_i (dvr[c]),
      .dv_i   (dvd[c]),
      .vld_o  (dvv[c+1]),
      .item_o (dvi[c+1]),
      .root_o (dvr[c+1]),
      .dv_o   (dvd[c+1])
    );
  end

  // Output register: choose root path or the precomputed result.
  logic                    out_valid_r;
  logic signed [DistW-1:0] dist_r;
  logic signed [GradW-1:0] grad_r [3];
  item_t                   fi;
  logic signed [GradW-1:0] gq [3];

  always_comb begin
    fi = dvi[QuoW];
    for (int a = 0; a < 3; a++) begin
      gq[a] = fi.neg[a] ? -GradW'(dvd[QuoW].quo[a]) : GradW'(dvd[QuoW].quo[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dvv[QuoW];
    end
    for (int a = 0; a < 3; a++) begin
      grad_r[a] <= fi.eucl ? gq[a] : fi.grad[a];
    end
    dist_r <= fi.eucl ? DistW'(dvr[QuoW]) : fi.dval;
  end

  assign out_valid           = out_valid_r;
  assign out_signed_distance = dist_r;
  assign out_grad_x          = grad_r[0];
  assign out_grad_y          = grad_r[1];
  assign out_grad_z          = grad_r[2];

  // A result never appears without an item having entered the chain.
  a_no_ghost: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(dvv[QuoW])) else $error("result without item");

  // An accepted item reaches the square-root chain the next cycle.
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s0_vld_r) else $error("item lost at entry");

  // Gradient magnitude never exceeds one; the check covers the x component.
  a_grad: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_grad_x <= GradW'(One) && out_grad_x >= -GradW'(One)))
    else $error("gradient out of range");

endmodule
